[rtl/qvr_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// qvr_pkg
// Shared constants for the quaternion vector rotator.
// ---------------------------------------------------------------------------
package qvr_pkg;

   localparam int NUM_AXES  = 3;
   localparam int NUM_TERMS = NUM_AXES * NUM_AXES;

endpackage : qvr_pkg
`default_nettype wire

[rtl/qvr_matrix.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// qvr_matrix
// Two pipeline stages: component products, then the nine rounded terms of
// the rotation matrix. The vector rides along with its item.
// ---------------------------------------------------------------------------
module qvr_matrix #(
   parameter int FRAC_BITS  = 14,
   parameter int DATA_WIDTH = 16,
   parameter int MAT_WIDTH  = 21
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [DATA_WIDTH-1:0] quat_x,
   input  logic signed [DATA_WIDTH-1:0] quat_y,
   input  logic signed [DATA_WIDTH-1:0] quat_z,
   input  logic signed [DATA_WIDTH-1:0] quat_w,
   input  logic signed [DATA_WIDTH-1:0] vec    [qvr_pkg::NUM_AXES],
   output logic                         out_valid,
   output logic signed [MAT_WIDTH-1:0]  term   [qvr_pkg::NUM_TERMS],
   output logic signed [DATA_WIDTH-1:0] vec_out[qvr_pkg::NUM_AXES]
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam int TW = MAT_WIDTH + FRAC_BITS;
   localparam logic signed [TW-1:0] ONE  = TW'(1) <<< (2 * FRAC_BITS);
   localparam logic signed [TW-1:0] HALF = TW'(1) <<< (FRAC_BITS - 1);

   // stage 1: products
   logic signed [PW-1:0] xx_in, yy_in, zz_in, xy_in, xz_in, yz_in, xw_in, yw_in, zw_in;
   logic signed [PW-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, xw_ff, yw_ff, zw_ff;
   logic signed [DATA_WIDTH-1:0] vec1_ff[qvr_pkg::NUM_AXES];
   logic                         valid1_ff;

   assign xx_in = quat_x * quat_x;
   assign yy_in = quat_y * quat_y;
   assign zz_in = quat_z * quat_z;
   assign xy_in = quat_x * quat_y;
   assign xz_in = quat_x * quat_z;
   assign yz_in = quat_y * quat_z;
   assign xw_in = quat_x * quat_w;
   assign yw_in = quat_y * quat_w;
   assign zw_in = quat_z * quat_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      xx_ff   <= xx_in;
      yy_ff   <= yy_in;
      zz_ff   <= zz_in;
      xy_ff   <= xy_in;
      xz_ff   <= xz_in;
      yz_ff   <= yz_in;
      xw_ff   <= xw_in;
      yw_ff   <= yw_in;
      zw_ff   <= zw_in;
      vec1_ff <= vec;
   end

   // stage 2: matrix terms, exact at 2F fraction bits, then rounded half up
   logic signed [TW-1:0]        raw_in [qvr_pkg::NUM_TERMS];
   logic signed [TW-1:0]        rnd_in [qvr_pkg::NUM_TERMS];
   logic signed [MAT_WIDTH-1:0] term_ff[qvr_pkg::NUM_TERMS];
   logic signed [DATA_WIDTH-1:0] vec2_ff[qvr_pkg::NUM_AXES];
   logic                         valid2_ff;

   always_comb begin
      raw_in[0] = ONE - ((TW'(yy_ff) + TW'(zz_ff)) <<< 1);
      raw_in[1] = (TW'(xy_ff) - TW'(zw_ff)) <<< 1;
      raw_in[2] = (TW'(xz_ff) + TW'(yw_ff)) <<< 1;
      raw_in[3] = (TW'(xy_ff) + TW'(zw_ff)) <<< 1;
      raw_in[4] = ONE - ((TW'(xx_ff) + TW'(zz_ff)) <<< 1);
      raw_in[5] = (TW'(yz_ff) - TW'(xw_ff)) <<< 1;
      raw_in[6] = (TW'(xz_ff) - TW'(yw_ff)) <<< 1;
      raw_in[7] = (TW'(yz_ff) + TW'(xw_ff)) <<< 1;
      raw_in[8] = ONE - ((TW'(xx_ff) + TW'(yy_ff)) <<< 1);
      for (int k = 0; k < qvr_pkg::NUM_TERMS; k++) begin
         rnd_in[k] = raw_in[k] + HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < qvr_pkg::NUM_TERMS; k++) begin
         term_ff[k] <= rnd_in[k][TW-1:FRAC_BITS];
      end
      vec2_ff <= vec1_ff;
   end

   assign out_valid = valid2_ff;
   assign term      = term_ff;
   assign vec_out   = vec2_ff;

endmodule : qvr_matrix
`default_nettype wire

[rtl/qvr_dot.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// qvr_dot
// Three pipeline stages: term-by-component products, row sums, then
// rounding and saturation into the result registers.
// ---------------------------------------------------------------------------
module qvr_dot #(
   parameter int FRAC_BITS  = 14,
   parameter int DATA_WIDTH = 16,
   parameter int MAT_WIDTH  = 21
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [MAT_WIDTH-1:0]  term[qvr_pkg::NUM_TERMS],
   input  logic signed [DATA_WIDTH-1:0] vec [qvr_pkg::NUM_AXES],
   output logic                         out_valid,
   output logic signed [DATA_WIDTH-1:0] rot [qvr_pkg::NUM_AXES],
   output logic                         overflow
);

   localparam int MW = MAT_WIDTH + DATA_WIDTH;
   localparam int SW = MW + 2;
   localparam int RW = SW - FRAC_BITS;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [RW-1:0] MAX_RND =
      {{(RW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
   localparam logic signed [RW-1:0] MIN_RND = ~MAX_RND;

   // stage 3: products
   logic signed [MW-1:0] prod_ff[qvr_pkg::NUM_TERMS];
   logic                 valid3_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < qvr_pkg::NUM_TERMS; k++) begin
         prod_ff[k] <= MW'(term[k]) * MW'(vec[k % qvr_pkg::NUM_AXES]);
      end
   end

   // stage 4: row sums plus rounding bias
   logic signed [SW-1:0] sum_in[qvr_pkg::NUM_AXES];
   logic signed [SW-1:0] sum_ff[qvr_pkg::NUM_AXES];
   logic                 valid4_ff;

   always_comb begin
      for (int r = 0; r < qvr_pkg::NUM_AXES; r++) begin
         sum_in[r] = SW'(prod_ff[3 * r]) + SW'(prod_ff[3 * r + 1])
                   + SW'(prod_ff[3 * r + 2]) + HALF;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // stage 5: drop fraction bits, clamp to the output width
   logic signed [RW-1:0]         rnd_in[qvr_pkg::NUM_AXES];
   logic signed [DATA_WIDTH-1:0] rot_in[qvr_pkg::NUM_AXES];
   logic [qvr_pkg::NUM_AXES-1:0] sat_in;
   logic signed [DATA_WIDTH-1:0] rot_ff[qvr_pkg::NUM_AXES];
   logic                         overflow_ff;
   logic                         valid5_ff;

   always_comb begin
      for (int r = 0; r < qvr_pkg::NUM_AXES; r++) begin
         rnd_in[r] = sum_ff[r][SW-1:FRAC_BITS];
         if (rnd_in[r] > MAX_RND) begin
            rot_in[r] = MAX_RND[DATA_WIDTH-1:0];
            sat_in[r] = 1'b1;
         end else if (rnd_in[r] < MIN_RND) begin
            rot_in[r] = MIN_RND[DATA_WIDTH-1:0];
            sat_in[r] = 1'b1;
         end else begin
            rot_in[r] = rnd_in[r][DATA_WIDTH-1:0];
            sat_in[r] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rot_ff      <= rot_in;
      overflow_ff <= |sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         valid3_ff <= in_valid;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
   end

   assign out_valid = valid5_ff;
   assign rot       = rot_ff;
   assign overflow  = overflow_ff;

endmodule : qvr_dot
`default_nettype wire

[rtl/quaternion_vector_rotator_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// quaternion_vector_rotator_unit
// Rotates a 3-vector by a fixed-point quaternion through its rotation matrix.
// ---------------------------------------------------------------------------
// Five-stage pipeline that takes one item every cycle: busy is always low.
// The result for each item is shown with rsp_valid high for a single cycle,
// in the order items came in; the receiver cannot hold results off.
// Stages: component products, rounded matrix terms, term-by-vector
// products, row sums, round and saturate. The quaternion is used as given
// (no normalization); rsp_overflow flags an item in which any output
// component was clamped.
// ---------------------------------------------------------------------------
module quaternion_vector_rotator_unit #(
   parameter int FRAC_BITS  = 14,
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_quat_x,
   input  logic signed [DATA_WIDTH-1:0] req_quat_y,
   input  logic signed [DATA_WIDTH-1:0] req_quat_z,
   input  logic signed [DATA_WIDTH-1:0] req_quat_w,
   input  logic signed [DATA_WIDTH-1:0] req_vec_x,
   input  logic signed [DATA_WIDTH-1:0] req_vec_y,
   input  logic signed [DATA_WIDTH-1:0] req_vec_z,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_rot_x,
   output logic signed [DATA_WIDTH-1:0] rsp_rot_y,
   output logic signed [DATA_WIDTH-1:0] rsp_rot_z,
   output logic                         rsp_overflow
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam int EW = ((PW > 2 * FRAC_BITS + 1) ? PW : 2 * FRAC_BITS + 1) + 3;
   localparam int MAT_WIDTH = EW - FRAC_BITS;

   logic signed [DATA_WIDTH-1:0] vec_in [qvr_pkg::NUM_AXES];
   logic signed [DATA_WIDTH-1:0] vec_mat[qvr_pkg::NUM_AXES];
   logic signed [MAT_WIDTH-1:0]  term   [qvr_pkg::NUM_TERMS];
   logic signed [DATA_WIDTH-1:0] rot    [qvr_pkg::NUM_AXES];
   logic                         accept;
   logic                         mat_valid;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign vec_in[0] = req_vec_x;
   assign vec_in[1] = req_vec_y;
   assign vec_in[2] = req_vec_z;

   qvr_matrix #(
      .FRAC_BITS (FRAC_BITS),
      .DATA_WIDTH(DATA_WIDTH),
      .MAT_WIDTH (MAT_WIDTH)
   ) u_matrix (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .quat_x   (req_quat_x),
      .quat_y   (req_quat_y),
      .quat_z   (req_quat_z),
      .quat_w   (req_quat_w),
      .vec      (vec_in),
      .out_valid(mat_valid),
      .term     (term),
      .vec_out  (vec_mat)
   );

   qvr_dot #(
      .FRAC_BITS (FRAC_BITS),
      .DATA_WIDTH(DATA_WIDTH),
      .MAT_WIDTH (MAT_WIDTH)
   ) u_dot (
      .clock    (clock),
      .reset    (reset),
      .in_valid (mat_valid),
      .term     (term),
      .vec      (vec_mat),
      .out_valid(rsp_valid),
      .rot      (rot),
      .overflow (rsp_overflow)
   );

   assign rsp_rot_x = rot[0];
   assign rsp_rot_y = rot[1];
   assign rsp_rot_z = rot[2];

endmodule : quaternion_vector_rotator_unit
`default_nettype wire
